>>> rtl/pcs_pkg.sv
// Package for the pairwise cascade summing block: constants, the binary64
// adder request and response types. No dependencies.
`default_nettype none
package pcs_pkg;

	localparam int PCS_LEVELS = 32;
	localparam int CNT_W = 32;

	// Default quiet NaN returned for infinity minus infinity.
	localparam logic [63:0] FP_DEFAULT_NAN = 64'hFFF8_0000_0000_0000;
	localparam logic [63:0] FP_QUIET_BIT = 64'h0008_0000_0000_0000;
	localparam logic [10:0] FP_EXP_MAX = 11'h7FF;

	typedef struct packed {
		logic        start;
		logic [63:0] a;
		logic [63:0] b;
	} fadd_req_t;

	typedef struct packed {
		logic        busy;
		logic        done;
		logic [63:0] res;
	} fadd_rsp_t;

endpackage
`default_nettype wire

>>> rtl/pcs_if.sv
// Stream interfaces of the pairwise cascade summing block: sample input and
// result output, each with valid and ready. No dependencies.
`default_nettype none
interface pcs_in_if;
	logic        valid;
	logic        ready;
	logic [63:0] sample;
	logic        last;

	modport source (output valid, output sample, output last, input ready);
	modport sink (input valid, input sample, input last, output ready);
endinterface

interface pcs_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] total;
	logic [31:0] items_summed;
	logic        overflow;

	modport source (output valid, output total, output items_summed, output overflow,
		input ready);
	modport sink (input valid, input total, input items_summed, input overflow,
		output ready);
endinterface
`default_nettype wire

>>> rtl/pcs_fadd.sv
// Multi-cycle binary64 adder, round to nearest even, with special values.
// Depends on pcs_pkg for the request and response types.
`default_nettype none
module pcs_fadd
	import pcs_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  fadd_req_t req,
	output fadd_rsp_t rsp
);

	localparam logic [2:0] A_IDLE  = 3'd0;
	localparam logic [2:0] A_ALIGN = 3'd1;
	localparam logic [2:0] A_NORM  = 3'd2;
	localparam logic [2:0] A_ROUND = 3'd3;

	logic [2:0] state_q;
	logic [12:0] xe_q, ye_q, e_q;
	logic [55:0] xm_q, ym_q;
	logic sx_q, sy_q, s_q;
	logic [56:0] r_q;
	logic [63:0] res_q;
	logic done_q;

	// Unpack and order the operands by magnitude.
	logic a_nan, b_nan, a_inf, b_inf, swap;
	logic [63:0] x, y, spec_res;
	logic spec;

	always_comb begin
		a_nan = (req.a[62:52] == FP_EXP_MAX) && (req.a[51:0] != 52'd0);
		b_nan = (req.b[62:52] == FP_EXP_MAX) && (req.b[51:0] != 52'd0);
		a_inf = (req.a[62:52] == FP_EXP_MAX) && (req.a[51:0] == 52'd0);
		b_inf = (req.b[62:52] == FP_EXP_MAX) && (req.b[51:0] == 52'd0);
		swap = req.b[62:0] > req.a[62:0];
		x = swap ? req.b : req.a;
		y = swap ? req.a : req.b;
		spec = 1'b1;
		if (a_nan) begin
			spec_res = req.a | FP_QUIET_BIT;
		end else if (b_nan) begin
			spec_res = req.b | FP_QUIET_BIT;
		end else if (a_inf && b_inf && (req.a[63] != req.b[63])) begin
			spec_res = FP_DEFAULT_NAN;
		end else if (a_inf) begin
			spec_res = req.a;
		end else if (b_inf) begin
			spec_res = req.b;
		end else begin
			spec = 1'b0;
			spec_res = req.a;
		end
	end

	// Alignment with a sticky bit, then the add or subtract.
	logic [12:0] d;
	logic [55:0] ysh, ymask, yal;
	logic sticky;
	logic [56:0] sum;

	always_comb begin
		d = xe_q - ye_q;
		if (d >= 13'd56) begin
			ysh = 56'd0;
			sticky = |ym_q;
		end else begin
			ysh = ym_q >> d[5:0];
			ymask = (56'd1 << d[5:0]) - 56'd1;
			sticky = |(ym_q & ymask);
		end
		ymask = (56'd1 << d[5:0]) - 56'd1;
		yal = {ysh[55:1], ysh[0] | sticky};
		if (sx_q != sy_q) begin
			sum = {1'b0, xm_q} - {1'b0, yal};
		end else begin
			sum = {1'b0, xm_q} + {1'b0, yal};
		end
	end

	// Fine normalisation: at most eight single-bit steps.
	logic [56:0] rf;
	logic [12:0] ef;

	always_comb begin
		rf = r_q;
		ef = e_q;
		for (int k = 0; k < 8; k++) begin
			if (!rf[55] && (ef > 13'd1)) begin
				rf = {rf[55:0], 1'b0};
				ef = ef - 13'd1;
			end
		end
	end

	// Rounding and packing.
	logic round_up;
	logic [53:0] m54;
	logic [52:0] mant;
	logic [12:0] er;
	logic [63:0] packed_res;

	always_comb begin
		round_up = r_q[2] & (r_q[1] | r_q[0] | r_q[3]);
		m54 = {1'b0, r_q[55:3]} + {53'd0, round_up};
		if (m54[53]) begin
			mant = m54[53:1];
			er = e_q + 13'd1;
		end else begin
			mant = m54[52:0];
			er = e_q;
		end
		if (er >= 13'd2047) begin
			packed_res = {s_q, FP_EXP_MAX, 52'd0};
		end else if (mant[52]) begin
			packed_res = {s_q, er[10:0], mant[51:0]};
		end else begin
			packed_res = {s_q, 11'd0, mant[51:0]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= A_IDLE;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				A_IDLE: begin
					if (req.start) begin
						if (spec) begin
							res_q <= spec_res;
							done_q <= 1'b1;
						end else begin
							state_q <= A_ALIGN;
						end
					end
				end
				A_ALIGN: begin
					state_q <= A_NORM;
				end
				A_NORM: begin
					if (r_q[56]) begin
						state_q <= A_ROUND;
					end else if (r_q == 57'd0) begin
						res_q <= {s_q, 63'd0};
						done_q <= 1'b1;
						state_q <= A_IDLE;
					end else if (r_q[55] || (e_q == 13'd1)) begin
						state_q <= A_ROUND;
					end else if ((r_q[55:48] != 8'd0) || (e_q <= 13'd8)) begin
						state_q <= A_ROUND;
					end
				end
				A_ROUND: begin
					res_q <= packed_res;
					done_q <= 1'b1;
					state_q <= A_IDLE;
				end
				default: state_q <= A_IDLE;
			endcase
		end
	end

	// Datapath registers, no reset needed.
	always_ff @(posedge clk) begin
		case (state_q)
			A_IDLE: begin
				xe_q <= (x[62:52] == 11'd0) ? 13'd1 : {2'b00, x[62:52]};
				ye_q <= (y[62:52] == 11'd0) ? 13'd1 : {2'b00, y[62:52]};
				xm_q <= {x[62:52] != 11'd0, x[51:0], 3'b000};
				ym_q <= {y[62:52] != 11'd0, y[51:0], 3'b000};
				sx_q <= x[63];
				sy_q <= y[63];
			end
			A_ALIGN: begin
				r_q <= sum;
				e_q <= xe_q;
				// An exact zero is negative only when both operands were.
				s_q <= (sum == 57'd0) ? (sx_q & sy_q) : sx_q;
			end
			A_NORM: begin
				if (r_q[56]) begin
					r_q <= {1'b0, r_q[56:2], r_q[1] | r_q[0]};
					e_q <= e_q + 13'd1;
				end else if (r_q[55] || (e_q == 13'd1) || (r_q == 57'd0)) begin
					r_q <= r_q;
				end else if ((r_q[55:48] == 8'd0) && (e_q > 13'd8)) begin
					r_q <= {r_q[48:0], 8'd0};
					e_q <= e_q - 13'd8;
				end else begin
					r_q <= rf;
					e_q <= ef;
				end
			end
			default: begin
				r_q <= r_q;
			end
		endcase
	end

	assign rsp.busy = (state_q != A_IDLE);
	assign rsp.done = done_q;
	assign rsp.res = res_q;

endmodule
`default_nettype wire

>>> rtl/pairwise_cascade_sum_top.sv
// Top level of the pairwise cascade summing block: control, level memory and
// result register. Depends on pcs_pkg, pcs_if and pcs_fadd.
`default_nettype none
// Usage
// Samples (binary64 bit patterns) arrive on in_ch with last marking the end of
// a run; one request on out_ch per run carries the total, the sample count and
// a flag for samples dropped beyond the count limit of 2^min(LEVELS,32)-1.
// An even-indexed sample is held in a register. An odd-indexed one starts a
// pair addition in the shared binary64 adder (special operands are resolved
// directly, others pass through align, normalise and round), followed by
// one memory read and one addition per carry level, and one write. On average
// that is about one addition per sample.
// At the end of a run the block scans min(LEVELS,32) levels, one per cycle while
// the count bit is clear; for each set bit of the count it reads the level
// memory (a registered read) and adds it into the total.
// Reset clears the control state; the level memory is not cleared, as only
// levels written in the current run are read. A stalled receiver holds the
// result register; input samples are still taken until a next run finishes
// its sweep, which then waits for the register to free.
module pairwise_cascade_sum_top
	import pcs_pkg::*;
#(
	parameter int LEVELS = PCS_LEVELS
) (
	input wire logic   clk,
	input wire logic   arst_n,
	pcs_in_if.sink     in_ch,
	pcs_out_if.source  out_ch
);

	localparam int CAP = (LEVELS < 32) ? LEVELS : 32;
	localparam int LA = $clog2(LEVELS);
	localparam int IW = $clog2(CAP + 1);
	localparam logic [CNT_W:0] LIMIT = ({{CNT_W{1'b0}}, 1'b1} << CAP) - 1'b1;

	localparam logic [3:0] S_IDLE      = 4'd0;
	localparam logic [3:0] S_PAIR_WAIT = 4'd1;
	localparam logic [3:0] S_PAIR_RD   = 4'd2;
	localparam logic [3:0] S_SW_INIT   = 4'd3;
	localparam logic [3:0] S_SW_SCAN   = 4'd4;
	localparam logic [3:0] S_SW_RD     = 4'd5;
	localparam logic [3:0] S_SW_WAIT   = 4'd6;
	localparam logic [3:0] S_OUT       = 4'd7;

	logic [3:0] state_q;
	logic [CNT_W-1:0] cnt_q, pidx_q;
	logic [63:0] held_q, acc_q, tot_q;
	logic drop_q, last_q;
	logic [IW-1:0] p_q, i_q;
	logic ov_q;
	logic [63:0] o_total_q;
	logic [CNT_W-1:0] o_cnt_q;
	logic o_ovf_q;

	fadd_req_t add_req;
	fadd_rsp_t add_rsp;

	pcs_fadd u_fadd (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (add_req),
		.rsp   (add_rsp)
	);

	// Level memory.
	logic [63:0] lvl_mem [LEVELS];
	logic mem_we, mem_re;
	logic [LA-1:0] mem_waddr, mem_raddr;
	logic [63:0] mem_wdata, rdata_s1;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			lvl_mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rdata_s1 <= lvl_mem[mem_raddr];
		end
	end

	logic accept, full, chain;
	logic [CNT_W-1:0] pidx_sh, cnt_sh;

	assign accept = in_ch.valid && in_ch.ready;
	assign full = {1'b0, cnt_q} >= LIMIT;
	assign pidx_sh = pidx_q >> p_q;
	assign cnt_sh = cnt_q >> i_q;
	// Carry on while bit p of the pair index is set, below the top level.
	assign chain = ({{(CNT_W-IW){1'b0}}, p_q} < CNT_W'(CAP - 1)) && pidx_sh[0];

	always_comb begin
		add_req = '0;
		mem_we = 1'b0;
		mem_re = 1'b0;
		mem_waddr = p_q[LA-1:0];
		mem_raddr = p_q[LA-1:0];
		mem_wdata = add_rsp.res;
		unique case (state_q)
			S_IDLE: begin
				if (accept && !full && cnt_q[0]) begin
					add_req.start = 1'b1;
					add_req.a = held_q;
					add_req.b = in_ch.sample;
				end
			end
			S_PAIR_WAIT: begin
				if (add_rsp.done) begin
					mem_re = chain;
					mem_we = !chain;
				end
			end
			S_PAIR_RD: begin
				add_req.start = 1'b1;
				add_req.a = acc_q;
				add_req.b = rdata_s1;
			end
			S_SW_INIT: begin
				mem_we = cnt_q[0];
				mem_waddr = '0;
				mem_wdata = held_q;
			end
			S_SW_SCAN: begin
				mem_raddr = i_q[LA-1:0];
				mem_re = (i_q != IW'(CAP)) && cnt_sh[0];
			end
			S_SW_RD: begin
				add_req.start = 1'b1;
				add_req.a = tot_q;
				add_req.b = rdata_s1;
			end
			default: begin
				add_req = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			held_q <= '0;
			drop_q <= 1'b0;
			ov_q <= 1'b0;
		end else begin
			// In S_OUT the result register is handled by the state itself.
			if (ov_q && out_ch.ready && (state_q != S_OUT)) begin
				ov_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						last_q <= in_ch.last;
						if (full) begin
							drop_q <= 1'b1;
							if (in_ch.last) begin
								state_q <= S_SW_INIT;
							end
						end else begin
							cnt_q <= cnt_q + 1'b1;
							if (!cnt_q[0]) begin
								held_q <= in_ch.sample;
								if (in_ch.last) begin
									state_q <= S_SW_INIT;
								end
							end else begin
								pidx_q <= cnt_q;
								p_q <= IW'(1);
								state_q <= S_PAIR_WAIT;
							end
						end
					end
				end
				S_PAIR_WAIT: begin
					if (add_rsp.done) begin
						acc_q <= add_rsp.res;
						if (chain) begin
							state_q <= S_PAIR_RD;
						end else begin
							state_q <= last_q ? S_SW_INIT : S_IDLE;
						end
					end
				end
				S_PAIR_RD: begin
					p_q <= p_q + 1'b1;
					state_q <= S_PAIR_WAIT;
				end
				S_SW_INIT: begin
					tot_q <= '0;
					i_q <= '0;
					state_q <= S_SW_SCAN;
				end
				S_SW_SCAN: begin
					if (i_q == IW'(CAP)) begin
						state_q <= S_OUT;
					end else if (cnt_sh[0]) begin
						state_q <= S_SW_RD;
					end else begin
						i_q <= i_q + 1'b1;
					end
				end
				S_SW_RD: begin
					state_q <= S_SW_WAIT;
				end
				S_SW_WAIT: begin
					if (add_rsp.done) begin
						tot_q <= add_rsp.res;
						i_q <= i_q + 1'b1;
						state_q <= S_SW_SCAN;
					end
				end
				S_OUT: begin
					if (!ov_q || out_ch.ready) begin
						o_total_q <= tot_q;
						o_cnt_q <= cnt_q;
						o_ovf_q <= drop_q;
						ov_q <= 1'b1;
						cnt_q <= '0;
						held_q <= '0;
						drop_q <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ch.ready = (state_q == S_IDLE);
	assign out_ch.valid = ov_q;
	assign out_ch.total = o_total_q;
	assign out_ch.items_summed = o_cnt_q;
	assign out_ch.overflow = o_ovf_q;

	a_add_idle: assert property (@(posedge clk) disable iff (!arst_n)
		add_req.start |-> !add_rsp.busy)
		else $error("adder started while busy");

	a_cnt_limit: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, cnt_q} <= LIMIT)
		else $error("sample count beyond limit");

	a_read_use: assert property (@(posedge clk) disable iff (!arst_n)
		mem_re |=> (state_q == S_PAIR_RD) || (state_q == S_SW_RD))
		else $error("level read not consumed");

	a_no_rw: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> !mem_re)
		else $error("level read and write in the same cycle");

	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(ov_q) |-> $past(state_q == S_OUT))
		else $error("result loaded outside sweep end");

endmodule
`default_nettype wire

>>> dv/pcs_sum_checker.sv
// Checker for the pairwise cascade summing block: watches both streams,
// predicts each run total in binary64 and compares. Depends on pcs_pkg, pcs_if.
`timescale 1ns / 100ps
module pcs_sum_checker
	import pcs_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	pcs_in_if         in_mon,
	pcs_out_if        out_mon,
	output int        errors,
	output int        pending
);

	localparam int LVL_CAP = (PCS_LEVELS < 32) ? PCS_LEVELS : 32;
	localparam longint unsigned COUNT_LIMIT = (64'd1 << LVL_CAP) - 1;

	typedef struct {
		logic [63:0] total;
		logic [31:0] items_summed;
		logic        overflow;
	} run_result_t;

	run_result_t run_results_q[$];

	logic [63:0]    held_sample;
	longint unsigned run_count;
	real            level_sums[LVL_CAP];
	logic           dropped;

	function automatic bit is_nan(logic [63:0] v);
		return (v[62:52] == FP_EXP_MAX) && (v[51:0] != 52'd0);
	endfunction

	// Takes one accepted sample into the running sum and returns 1 with the
	// run total when it closes a run.
	function automatic bit accumulate_sample(logic [63:0] s, logic l, output run_result_t r);
		real             pair_sum;
		real             tot;
		int              p;
		longint unsigned first;
		if (run_count >= COUNT_LIMIT) begin
			dropped = 1'b1;
		end else begin
			if (run_count[0] == 1'b0) begin
				held_sample = s;
			end else begin
				pair_sum = $bitstoreal(held_sample) + $bitstoreal(s);
				first = run_count - 1;
				p = 1;
				while (p < LVL_CAP - 1 && first[p]) begin
					pair_sum = pair_sum + level_sums[p];
					p++;
				end
				level_sums[p] = pair_sum;
			end
			run_count++;
		end
		if (!l)
			return 1'b0;
		if (run_count[0])
			level_sums[0] = $bitstoreal(held_sample);
		tot = 0.0;
		for (int i = 0; i < LVL_CAP; i++) begin
			if (run_count[i])
				tot = tot + level_sums[i];
		end
		r.total = $realtobits(tot);
		r.items_summed = run_count[31:0];
		r.overflow = dropped;
		held_sample = '0;
		run_count = 0;
		dropped = 1'b0;
		return 1'b1;
	endfunction

	assign pending = run_results_q.size();

	initial begin
		errors = 0;
		held_sample = '0;
		run_count = 0;
		dropped = 1'b0;
		for (int i = 0; i < LVL_CAP; i++)
			level_sums[i] = 0.0;
	end

	always @(posedge clk) begin
		run_result_t r;
		run_result_t e;
		bit          bad;
		if (arst_n) begin
			if (in_mon.valid && in_mon.ready) begin
				if (accumulate_sample(in_mon.sample, in_mon.last, r))
					run_results_q.push_back(r);
			end
			if (out_mon.valid && out_mon.ready) begin
				if (run_results_q.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected result total=%h n=%0d ovf=%b",
							out_mon.total, out_mon.items_summed, out_mon.overflow);
				end else begin
					e = run_results_q.pop_front();
					// Any NaN pattern is taken as a match for an expected NaN.
					bad = !((out_mon.total == e.total) ||
						(is_nan(out_mon.total) && is_nan(e.total)));
					bad |= out_mon.items_summed !== e.items_summed;
					bad |= out_mon.overflow !== e.overflow;
					if (bad) begin
						errors++;
						if (errors <= 10)
							$display("mismatch: exp total=%h n=%0d ovf=%b, got total=%h n=%0d ovf=%b",
								e.total, e.items_summed, e.overflow, out_mon.total,
								out_mon.items_summed, out_mon.overflow);
					end
				end
			end
		end
	end

endmodule

>>> dv/tb_pairwise_cascade_sum_top.sv
// Testbench top for the pairwise cascade summing block: clock, reset, sample
// stimulus and result back-pressure. Depends on pcs_pkg, pcs_if, pcs_sum_checker.
`timescale 1ns / 100ps
module tb_pairwise_cascade_sum_top
	import pcs_pkg::*;
;

	localparam int TARGET_SAMPLES = 1450;
	localparam int CALM_TAIL = 250;
	localparam int CYCLE_LIMIT = 800000;
	localparam int DRAIN_CYCLES = 600;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   errors;
	int   pending;
	int   cycles = 0;
	int   samples_sent = 0;
	bit   idle_on = 1'b1;
	bit   long_hold = 1'b0;

	pcs_in_if  in_ch ();
	pcs_out_if out_ch ();

	pairwise_cascade_sum_top dut (.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch));
	pcs_sum_checker chk (.clk(clk), .arst_n(arst_n), .in_mon(in_ch), .out_mon(out_ch),
		.errors(errors), .pending(pending));

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// Receiver: random stalls, plus one long hold-off so that the block backs up.
	initial begin
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (long_hold) begin
				out_ch.ready = 1'b0;
				repeat (400) @(negedge clk);
				long_hold = 1'b0;
			end else if (idle_on && $urandom_range(0, 7) == 0) begin
				out_ch.ready = 1'b0;
				repeat ($urandom_range(1, 13) - 1) @(negedge clk);
			end else begin
				out_ch.ready = 1'b1;
			end
		end
	end

	function automatic logic [63:0] special_value();
		case ($urandom_range(0, 9))
			0: return 64'h7FF0_0000_0000_0000;
			1: return 64'hFFF0_0000_0000_0000;
			2: return 64'h7FF8_0000_0000_0000;
			3: return 64'h8000_0000_0000_0000;
			4: return 64'h0000_0000_0000_0000;
			5: return {1'b0, 11'd0, 20'd0, $urandom()};
			6: return 64'h7FEF_FFFF_FFFF_FFFF;
			7: return 64'hFFEF_FFFF_FFFF_FFFF;
			8: return 64'h0010_0000_0000_0000;
			default: return 64'h3FF0_0000_0000_0000;
		endcase
	endfunction

	// Mostly ordinary numbers of similar size, so that sums and cancellations
	// are meaningful; now and then raw bit patterns or special values.
	function automatic logic [63:0] pick_sample();
		logic [10:0] ex;
		case ($urandom_range(0, 9))
			0: return {$urandom(), $urandom()};
			1: return special_value();
			2: begin
				ex = 11'($urandom_range(0, 60));
				return {$urandom_range(0, 1) == 1, ex, 20'($urandom()), $urandom()};
			end
			default: begin
				ex = 11'($urandom_range(1003, 1043));
				return {$urandom_range(0, 1) == 1, ex, 20'($urandom()), $urandom()};
			end
		endcase
	endfunction

	task automatic send_sample(logic [63:0] s, logic l);
		if (idle_on && $urandom_range(0, 7) == 0) begin
			in_ch.valid = 1'b0;
			repeat ($urandom_range(1, 13)) @(negedge clk);
		end
		in_ch.valid = 1'b1;
		in_ch.sample = s;
		in_ch.last = l;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		@(negedge clk);
		samples_sent++;
	endtask

	task automatic send_run(int len, bit specials);
		for (int i = 0; i < len; i++)
			send_sample(specials ? special_value() : pick_sample(), i == len - 1);
	endtask

	task automatic wait_drained();
		in_ch.valid = 1'b0;
		while (pending != 0) @(negedge clk);
	endtask

	initial begin
		int len;
		in_ch.valid = 1'b0;
		in_ch.sample = '0;
		in_ch.last = 1'b0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: lone sample, one pair, odd and power-of-two lengths.
		send_sample(64'h3FF0_0000_0000_0000, 1'b1);
		send_sample(64'h4000_0000_0000_0000, 1'b0);
		send_sample(64'hC000_0000_0000_0000, 1'b1);
		send_sample(64'h7FF0_0000_0000_0000, 1'b0);
		send_sample(64'hFFF0_0000_0000_0000, 1'b1);
		send_sample(64'h8000_0000_0000_0000, 1'b0);
		send_sample(64'h8000_0000_0000_0000, 1'b0);
		send_sample(64'h0000_0000_0000_0001, 1'b1);
		send_sample(64'h7FEF_FFFF_FFFF_FFFF, 1'b0);
		send_sample(64'h7FEF_FFFF_FFFF_FFFF, 1'b1);
		send_sample(64'hFFF8_0000_0000_0000, 1'b1);
		send_sample(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
		send_sample(64'h0000_0000_0000_0000, 1'b1);
		send_run(8, 1'b1);
		send_run(7, 1'b0);
		wait_drained();

		// Long receiver hold-off while samples keep coming.
		long_hold = 1'b1;
		for (int r = 0; r < 6; r++)
			send_run($urandom_range(3, 12), 1'b0);
		wait_drained();

		while (samples_sent < TARGET_SAMPLES) begin
			if (samples_sent > TARGET_SAMPLES - CALM_TAIL)
				idle_on = 1'b0;
			len = ($urandom_range(0, 15) == 0) ? $urandom_range(64, 140) : $urandom_range(1, 33);
			send_run(len, $urandom_range(0, 19) == 0);
			if ($urandom_range(0, 19) == 0)
				wait_drained();
		end
		in_ch.valid = 1'b0;

		while (pending != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (errors == 0 && pending == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
